### hw/rtl/las_pkg.sv
// Shared types and constants for the local alignment score block.
`timescale 1ns / 1ps

package las_pkg;

	localparam int SYM_W   = 8;
	localparam int SCORE_W = 10;
	localparam int CALC_W  = 12;
	localparam int MATCH_W = 4;
	localparam int PEN_W   = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1023;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

	// item kinds on the input tuser
	localparam logic OP_TARGET = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT
	} las_state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic emit;
	} las_cmd_t;

	typedef struct packed {
		logic sweep_ok;
		logic rd_last;
		logic last_q;
		logic out_free;
	} las_status_t;

endpackage

### hw/rtl/las_ctrl.sv
// Controller state machine for the local alignment score block.
`timescale 1ns / 1ps

module las_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	input  logic                in_last,
	output logic                in_ready,
	input  las_pkg::las_status_t status,
	output las_pkg::las_cmd_t   cmd
);
	import las_pkg::*;

	las_state_t state_q;
	las_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.issue  = 1'b0;
		cmd.emit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && in_op == OP_QUERY) begin
					if (status.sweep_ok) begin
						state_d = ST_SWEEP;
					end else if (in_last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SWEEP: begin
				cmd.issue = 1'b1;
				if (status.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// final cell retires this cycle
				state_d = status.last_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/las_dp.sv
// Datapath: target and column memories, cell update, counters and result register.
`timescale 1ns / 1ps

module las_dp #(
	parameter int MAX_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  las_pkg::las_cmd_t             cmd,
	output las_pkg::las_status_t          status,
	input  logic                          cfg_we,
	input  logic [las_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [las_pkg::PEN_W-1:0]     cfg_data,
	input  logic                          in_op,
	input  logic [las_pkg::SYM_W-1:0]     in_symbol,
	input  logic                          in_last,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [las_pkg::SCORE_W-1:0]   out_score,
	output logic                          out_trunc
);
	import las_pkg::*;

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int QL_W  = $clog2(MAX_LEN + 2);
	localparam logic [LEN_W-1:0] MAX_TL = LEN_W'(MAX_LEN);
	localparam logic [QL_W-1:0]  MAX_QL = QL_W'(MAX_LEN);

	// configuration
	logic [MATCH_W-1:0]       match_q;
	logic signed [PEN_W-1:0]  mismatch_q;
	logic signed [PEN_W-1:0]  gap_q;

	// sequence state
	logic [LEN_W-1:0] tlen_q;
	logic             tdone_q;
	logic             ovf_q;
	logic [QL_W-1:0]  qlen_q;
	logic [LEN_W-1:0] fill_q;
	logic [SCORE_W-1:0] best_q;
	logic [SYM_W-1:0] sym_q;
	logic             last_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [SCORE_W-1:0] diag_q;
	logic [SCORE_W-1:0] up_q;

	// read stage
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [SYM_W-1:0]   tgt_s1;
	logic [SCORE_W-1:0] col_s1;
	logic               colv_s1;

	// result register
	logic               out_valid_q;
	logic [SCORE_W-1:0] out_score_q;
	logic               out_trunc_q;

	logic [SYM_W-1:0]   tgt_mem [MAX_LEN];
	logic [SCORE_W-1:0] col_mem [MAX_LEN];

	logic               tgt_acc;
	logic               qry_acc;
	logic [LEN_W-1:0]   tgt_base;
	logic               tgt_room;
	logic               qry_first;

	logic [SCORE_W-1:0]       left;
	logic signed [CALC_W-1:0] left_x;
	logic signed [CALC_W-1:0] diag_x;
	logic signed [CALC_W-1:0] up_x;
	logic signed [CALC_W-1:0] gap_x;
	logic signed [CALC_W-1:0] sub_x;
	logic signed [CALC_W-1:0] lg;
	logic signed [CALC_W-1:0] ug;
	logic signed [CALC_W-1:0] dg;
	logic signed [CALC_W-1:0] m1;
	logic signed [CALC_W-1:0] m2;
	logic signed [CALC_W-1:0] m3;
	logic [SCORE_W-1:0]       cell_score;

	assign tgt_acc   = cmd.accept && in_op == OP_TARGET;
	assign qry_acc   = cmd.accept && in_op == OP_QUERY;
	assign tgt_base  = tdone_q ? '0 : tlen_q;
	assign tgt_room  = tgt_base < MAX_TL;
	assign qry_first = qlen_q == '0;

	assign status.sweep_ok = (qlen_q < QL_W'(MAX_LEN)) && (tlen_q != '0);
	assign status.rd_last  = (LEN_W'(rd_idx_q) + LEN_W'(1)) == tlen_q;
	assign status.last_q   = last_q;
	assign status.out_free = !out_valid_q || out_ready;

	// cell update
	assign left   = colv_s1 ? col_s1 : '0;
	assign left_x = $signed({2'b00, left});
	assign diag_x = $signed({2'b00, diag_q});
	assign up_x   = $signed({2'b00, up_q});
	assign gap_x  = $signed({{(CALC_W-PEN_W){gap_q[PEN_W-1]}}, gap_q});
	assign sub_x  = (tgt_s1 == sym_q) ? $signed({{(CALC_W-MATCH_W){1'b0}}, match_q})
		: $signed({{(CALC_W-PEN_W){mismatch_q[PEN_W-1]}}, mismatch_q});
	assign lg = left_x + gap_x;
	assign ug = up_x + gap_x;
	assign dg = diag_x + sub_x;
	assign m1 = (lg > $signed(CALC_W'(0))) ? lg : $signed(CALC_W'(0));
	assign m2 = (ug > m1) ? ug : m1;
	assign m3 = (dg > m2) ? dg : m2;
	assign cell_score = (m3 > $signed({2'b00, SCORE_MAX})) ? SCORE_MAX : m3[SCORE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= MATCH_W'(2);
			mismatch_q <= -PEN_W'(2);
			gap_q      <= -PEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MATCH:    match_q    <= cfg_data[MATCH_W-1:0];
				REG_MISMATCH: mismatch_q <= cfg_data;
				REG_GAP:      gap_q      <= cfg_data;
				default:      ;
			endcase
		end
	end

	// target bookkeeping; a target beat after a finished target starts a new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q  <= '0;
			tdone_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (tgt_acc) begin
			if (tgt_room) begin
				tlen_q <= tgt_base + LEN_W'(1);
			end else begin
				tlen_q <= tgt_base;
			end
			ovf_q   <= (tdone_q ? 1'b0 : ovf_q) | !tgt_room;
			tdone_q <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q <= '0;
		end else if (cmd.emit) begin
			qlen_q <= '0;
		end else if (qry_acc && qlen_q <= MAX_QL) begin
			qlen_q <= qlen_q + QL_W'(1);
		end
	end

	// fill count: column entries at or above it read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (qry_acc && qry_first) begin
			fill_q <= '0;
		end else if (v_s1 && LEN_W'(idx_s1) >= fill_q) begin
			fill_q <= LEN_W'(idx_s1) + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (qry_acc && qry_first) begin
			best_q <= '0;
		end else if (v_s1 && cell_score > best_q) begin
			best_q <= cell_score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (qry_acc) begin
			sym_q    <= in_symbol;
			last_q   <= in_last;
			rd_idx_q <= '0;
			diag_q   <= '0;
			up_q     <= '0;
		end else begin
			if (cmd.issue) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (v_s1) begin
				diag_q <= left;
				up_q   <= cell_score;
			end
		end
		if (cmd.issue) begin
			idx_s1  <= rd_idx_q;
			colv_s1 <= LEN_W'(rd_idx_q) < fill_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tgt_acc && tgt_room) begin
			tgt_mem[tgt_base[IDX_W-1:0]] <= in_symbol;
		end
		if (cmd.issue) begin
			tgt_s1 <= tgt_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			col_mem[idx_s1] <= cell_score;
		end
		if (cmd.issue) begin
			col_s1 <= col_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_score_q <= best_q;
			out_trunc_q <= ovf_q || (qlen_q > MAX_QL);
		end
	end

	assign out_valid = out_valid_q;
	assign out_score = out_score_q;
	assign out_trunc = out_trunc_q;

endmodule

### hw/rtl/local_alignment_score.sv
// Top level of the local alignment score block.
//
//   channel   dir  beat fields
//   s_axis    in   tdata = symbol, tuser = op (0 target, 1 query), tlast = last
//   m_axis    out  tdata[9:0] = score, tuser = truncated
//   cfg       in   cfg_index selects match, mismatch or gap score; cfg_data holds it
//
// A target beat is stored without leaving the idle state. A query beat runs a column
// sweep while the stored target is non-empty and the query is within MAX_LEN; the sweep
// updates one cell per cycle through the column memory port, then passes a drain state;
// otherwise the beat is taken in the idle state. A last query beat then goes to result load.
// Reset needs no clearing pass: a fill count masks stale column entries.
// A finished result waits in an output register while new beats are taken; the
// block stalls only when a second result is ready before the first is taken.
`timescale 1ns / 1ps

module local_alignment_score #(
	parameter int MAX_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] symbol
	input  logic                          s_axis_tuser,  // [0] op
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,  // [9:0] score, rest zero
	output logic                          m_axis_tuser,  // [0] truncated
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [las_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [las_pkg::PEN_W-1:0]     cfg_data
);
	import las_pkg::*;

	las_cmd_t           cmd;
	las_status_t        status;
	logic [SCORE_W-1:0] score;

	assign cfg_ready = 1'b1;

	las_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	las_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_axis_tuser),
		.in_symbol (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_score (score),
		.out_trunc (m_axis_tuser)
	);

	assign m_axis_tdata = {{(16-SCORE_W){1'b0}}, score};

endmodule

### hw/rtl/las_checker.sv
// Port-level checks for the local alignment score block, bound to the top level.
`timescale 1ns / 1ps

module las_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	import las_pkg::*;

	// score never reaches the pad bits
	a_score_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:SCORE_W] == '0)
		else $error("score pad bits set");

	// a target beat does not stall the input: it is ready again in the cycle after
	a_target_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TARGET |=> s_axis_tready)
		else $error("input stalled after target beat");

	// a last query beat always moves to the sweep or to result load, so input is not ready
	a_query_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY && s_axis_tlast
		|=> !s_axis_tready)
		else $error("input ready right after last query beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind local_alignment_score las_checker u_las_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
